>>> rtl/sgr_color_code_validator_macros.svh
// Assertion macros shared by the checker files of the colour code validator.
// Depends on nothing; take it in with a plain include of the bare file name.
`ifndef SGR_COLOR_CODE_VALIDATOR_MACROS_SVH
`define SGR_COLOR_CODE_VALIDATOR_MACROS_SVH

// Implication check, clocked on clk and quiet during reset.
`define SGR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check, clocked on clk and quiet during reset.
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sgr_cv_pkg.sv
// Package of the SGR colour code validator: codes, beat types and the
// number check functions. Depends on nothing.
`timescale 1ns / 1ps

package sgr_cv_pkg;

    // Widths of the beat fields and the state.
    localparam int unsigned CuWidth    = 16;
    localparam int unsigned AccWidth   = 10;
    localparam int unsigned PhaseWidth = 3;
    localparam int unsigned VerdWidth  = 2;

    // Character codes.
    localparam logic [CuWidth-1:0] CU_NUL  = 16'd0;
    localparam logic [CuWidth-1:0] CU_SEMI = 16'd59;
    localparam logic [CuWidth-1:0] CU_ZERO = 16'd48;
    localparam logic [CuWidth-1:0] CU_NINE = 16'd57;

    // Parse phases: normal code, expecting a colour mode; 3..1 bytes to come.
    localparam logic [PhaseWidth-1:0] PH_NORMAL = 3'd0;
    localparam logic [PhaseWidth-1:0] PH_BYTE1  = 3'd1;
    localparam logic [PhaseWidth-1:0] PH_BYTE3  = 3'd3;
    localparam logic [PhaseWidth-1:0] PH_XCOLOR = 3'd4;

    // Numbers of special meaning.
    localparam logic [AccWidth-1:0] ACC_MAX    = 10'd1023;
    localparam logic [AccWidth-1:0] BYTE_MAX   = 10'd255;
    localparam logic [AccWidth-1:0] N_FG_EXT   = 10'd38;
    localparam logic [AccWidth-1:0] N_BG_EXT   = 10'd48;
    localparam logic [AccWidth-1:0] N_MODE_RGB = 10'd2;
    localparam logic [AccWidth-1:0] N_MODE_IDX = 10'd5;

    // Verdict codes.
    localparam logic [VerdWidth-1:0] VERDICT_NONE    = 2'd0;
    localparam logic [VerdWidth-1:0] VERDICT_VALID   = 2'd1;
    localparam logic [VerdWidth-1:0] VERDICT_INVALID = 2'd2;

    // One input beat.
    typedef struct packed {
        logic [CuWidth-1:0] code_unit;
        logic               terminal;
    } item_t;

    // Outcome of finishing a number.
    typedef struct packed {
        logic                  ok;
        logic [PhaseWidth-1:0] phase;
    } finish_t;

    // Control from the top level to the parser.
    typedef struct packed {
        logic  consume;
        item_t item;
    } parse_ctl_t;

    // Status from the parser.
    typedef struct packed {
        logic                 is_end;
        logic [VerdWidth-1:0] verdict;
    } parse_sts_t;

    // Plain SGR codes that stand on their own.
    function automatic logic plain_code(input logic [AccWidth-1:0] n);
        logic r;
        begin
            r = (n <= 10'd4) || (n == 10'd7) || (n == 10'd9)
                || (n == 10'd21) || (n == 10'd22) || (n == 10'd23) || (n == 10'd24)
                || (n == 10'd25) || (n == 10'd27) || (n == 10'd29)
                || ((n >= 10'd30) && (n <= 10'd37)) || (n == 10'd39)
                || ((n >= 10'd40) && (n <= 10'd47)) || (n == 10'd49)
                || (n == 10'd53) || (n == 10'd55) || (n == 10'd59)
                || ((n >= 10'd90) && (n <= 10'd97))
                || ((n >= 10'd100) && (n <= 10'd107));
            return r;
        end
    endfunction

    // Checks a finished number against the phase and gives the next phase.
    // A failing number leaves the phase as it was.
    function automatic finish_t finish_number(input logic [AccWidth-1:0]   n,
                                              input logic [PhaseWidth-1:0] phase);
        finish_t f;
        begin
            f.ok    = 1'b0;
            f.phase = phase;
            if (phase == PH_NORMAL)
            begin
                if ((n == N_FG_EXT) || (n == N_BG_EXT))
                begin
                    f.ok    = 1'b1;
                    f.phase = PH_XCOLOR;
                end
                else
                begin
                    f.ok = plain_code(n);
                end
            end
            else if (phase == PH_XCOLOR)
            begin
                if (n == N_MODE_RGB)
                begin
                    f.ok    = 1'b1;
                    f.phase = PH_BYTE3;
                end
                else if (n == N_MODE_IDX)
                begin
                    f.ok    = 1'b1;
                    f.phase = PH_BYTE1;
                end
            end
            else if ((phase >= PH_BYTE1) && (phase <= PH_BYTE3))
            begin
                if (n <= BYTE_MAX)
                begin
                    f.ok    = 1'b1;
                    f.phase = phase - PH_BYTE1;
                end
            end
            return f;
        end
    endfunction

endpackage

>>> rtl/sgr_cv_in_stage.sv
// Input register of the SGR colour code validator: holds one beat until the
// parser takes it. Depends on sgr_cv_pkg.
`timescale 1ns / 1ps

module sgr_cv_in_stage
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sgr_cv_pkg::CuWidth-1:0]   code_unit,
    input  logic                             terminal,
    input  logic                             consume,
    output logic                             hold_valid,
    output sgr_cv_pkg::item_t                item
);

    logic              valid_reg;
    logic              valid_next;
    sgr_cv_pkg::item_t item_reg;

    // The register takes a new beat whenever it is empty or is being drained.
    assign in_ready   = !valid_reg || consume;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.code_unit <= code_unit;
            item_reg.terminal  <= terminal;
        end
    end

    assign hold_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/sgr_cv_parser.sv
// Parser state of the SGR colour code validator: updates the number, phase
// and error state for each beat and forms the verdict. Depends on sgr_cv_pkg.
`timescale 1ns / 1ps

module sgr_cv_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sgr_cv_pkg::parse_ctl_t ctl,
    output sgr_cv_pkg::parse_sts_t sts
);

    logic [sgr_cv_pkg::PhaseWidth-1:0] phase_reg, phase_next;
    logic [sgr_cv_pkg::AccWidth-1:0]   acc_reg, acc_next;
    logic                              error_reg, error_next;
    logic [1:0]                        units_reg, units_next;
    logic                              zero_reg, zero_next;

    logic                              is_end;
    logic                              is_semi;
    logic                              is_digit;
    sgr_cv_pkg::finish_t               fin;
    logic [sgr_cv_pkg::AccWidth+3:0]   acc_wide;
    logic [sgr_cv_pkg::VerdWidth-1:0]  verdict;

    // Classify the beat.
    assign is_end   = ctl.item.terminal || (ctl.item.code_unit == sgr_cv_pkg::CU_NUL);
    assign is_semi  = ctl.item.code_unit == sgr_cv_pkg::CU_SEMI;
    assign is_digit = (ctl.item.code_unit >= sgr_cv_pkg::CU_ZERO)
                      && (ctl.item.code_unit <= sgr_cv_pkg::CU_NINE);

    // Finish the number held so far, and extend it by one digit.
    assign fin      = sgr_cv_pkg::finish_number(acc_reg, phase_reg);
    assign acc_wide = ({4'd0, acc_reg} * 14'd10) + {10'd0, ctl.item.code_unit[3:0]};

    // Verdict at the end of a string.
    always_comb
    begin
        if (units_reg == 2'd0)
        begin
            verdict = sgr_cv_pkg::VERDICT_NONE;
        end
        else if ((units_reg <= 2'd2) && zero_reg)
        begin
            verdict = sgr_cv_pkg::VERDICT_NONE;
        end
        else if (error_reg)
        begin
            verdict = sgr_cv_pkg::VERDICT_INVALID;
        end
        else if (fin.ok)
        begin
            verdict = sgr_cv_pkg::VERDICT_VALID;
        end
        else
        begin
            verdict = sgr_cv_pkg::VERDICT_INVALID;
        end
    end

    // Next state for one consumed beat.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        error_next = error_reg;
        units_next = units_reg;
        zero_next  = zero_reg;
        if (ctl.consume)
        begin
            if (is_end)
            begin
                phase_next = sgr_cv_pkg::PH_NORMAL;
                acc_next   = '0;
                error_next = 1'b0;
                units_next = 2'd0;
                zero_next  = 1'b1;
            end
            else
            begin
                if (units_reg != 2'd3)
                begin
                    units_next = units_reg + 2'd1;
                end
                if (ctl.item.code_unit != sgr_cv_pkg::CU_ZERO)
                begin
                    zero_next = 1'b0;
                end
                if (!error_reg)
                begin
                    if (is_semi)
                    begin
                        phase_next = fin.phase;
                        error_next = !fin.ok;
                        acc_next   = '0;
                    end
                    else if (is_digit)
                    begin
                        if (acc_wide > {4'd0, sgr_cv_pkg::ACC_MAX})
                        begin
                            acc_next = sgr_cv_pkg::ACC_MAX;
                        end
                        else
                        begin
                            acc_next = acc_wide[sgr_cv_pkg::AccWidth-1:0];
                        end
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sgr_cv_pkg::PH_NORMAL;
            acc_reg   <= '0;
            error_reg <= 1'b0;
            units_reg <= 2'd0;
            zero_reg  <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            error_reg <= error_next;
            units_reg <= units_next;
            zero_reg  <= zero_next;
        end
    end

    assign sts.is_end  = is_end;
    assign sts.verdict = verdict;

endmodule

>>> rtl/sgr_cv_out_stage.sv
// Result register of the SGR colour code validator: holds one verdict beat
// until the receiver takes it. Depends on sgr_cv_pkg.
`timescale 1ns / 1ps

module sgr_cv_out_stage
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [sgr_cv_pkg::VerdWidth-1:0]   load_verdict,
    output logic                               free,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sgr_cv_pkg::VerdWidth-1:0]   verdict
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [sgr_cv_pkg::VerdWidth-1:0] verdict_reg;

    // Room for a new verdict when empty or when the held one leaves now.
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= load_verdict;
        end
    end

    assign out_valid = valid_reg;
    assign verdict   = verdict_reg;

endmodule

>>> rtl/sgr_color_code_validator.sv
// SGR colour code validator, top level.
// Usage: a colour string enters one UTF-16 code unit per beat on the input
// channel (in_valid, in_ready, code_unit, terminal). A beat with terminal
// set, or a code unit of zero, ends the string; that beat alone yields one
// beat on the output channel (out_valid, out_ready, verdict): 0 for no
// colour or default, 1 for valid SGR codes, 2 for invalid.
// Throughput: one beat per cycle, set by the update of the parser state from the
// input register; a terminating beat stalls there while the result register is full.
// A terminating beat accepted into the input register is moved into the result
// register once that register is free, and its verdict then stays on the output
// channel until the receiver takes it.
// Reset clears both registers and returns the parser to the start of a
// string; in_ready is high out of reset.
// When the receiver stalls, the verdict waits in the result register while
// further characters keep flowing; only a second terminating beat holds in
// the input register, and in_ready drops until the verdict is taken.
// Depends on sgr_cv_pkg, sgr_cv_in_stage, sgr_cv_parser, sgr_cv_out_stage.
`timescale 1ns / 1ps

module sgr_color_code_validator
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [sgr_cv_pkg::CuWidth-1:0]     code_unit,
    input  logic                               terminal,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sgr_cv_pkg::VerdWidth-1:0]   verdict
);

    logic                   hold_valid;
    sgr_cv_pkg::item_t      item;
    logic                   out_free;
    logic                   consume;
    sgr_cv_pkg::parse_ctl_t ctl;
    sgr_cv_pkg::parse_sts_t sts;

    // A held beat moves on unless it ends a string and the result slot is full.
    assign consume     = hold_valid && (!sts.is_end || out_free);
    assign ctl.consume = consume;
    assign ctl.item    = item;

    sgr_cv_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_unit  (code_unit),
        .terminal   (terminal),
        .consume    (consume),
        .hold_valid (hold_valid),
        .item       (item)
    );

    sgr_cv_parser u_parser
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts)
    );

    sgr_cv_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (consume && sts.is_end),
        .load_verdict (sts.verdict),
        .free         (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .verdict      (verdict)
    );

endmodule

>>> rtl/sgr_cv_checker.sv
// Port checker of the SGR colour code validator, bound to the top level.
// Depends on sgr_cv_pkg and sgr_color_code_validator_macros.svh.
`timescale 1ns / 1ps
`include "sgr_color_code_validator_macros.svh"

module sgr_cv_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [sgr_cv_pkg::VerdWidth-1:0]   verdict
);

    // A stalled verdict beat stays and keeps its value.
    `SGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(verdict), "verdict beat dropped or changed while stalled")

    // The verdict is never the unused code.
    `SGR_ASSERT_IMPL(a_verdict_code, out_valid, (verdict == sgr_cv_pkg::VERDICT_NONE) || (verdict == sgr_cv_pkg::VERDICT_VALID) || (verdict == sgr_cv_pkg::VERDICT_INVALID), "verdict holds the unused code")

    // The input side only stalls behind a stalled verdict.
    `SGR_ASSERT_IMPL(a_ready_cause, !in_ready, out_valid && !out_ready, "input stalled without a stalled verdict")

    // A freshly presented input beat is never refused while the output is idle.
    `SGR_ASSERT_IMPL(a_idle_ready, in_valid && !out_valid, in_ready, "input refused with an empty result slot")

endmodule

bind sgr_color_code_validator sgr_cv_checker u_sgr_cv_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict)
);

>>> dv/tb_top.sv
// Testbench of the SGR colour code validator: random and directed colour strings
// are driven beat by beat and each verdict is checked against a local predictor.
// Depends on sgr_cv_pkg and sgr_color_code_validator.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned UNITS_PER_PHASE = 250;
    localparam int unsigned REPORT_MAX      = 10;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic [sgr_cv_pkg::CuWidth-1:0]   code_unit = '0;
    logic                             terminal  = 1'b0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [sgr_cv_pkg::VerdWidth-1:0] verdict;

    // Stimulus and expectation stores.
    sgr_cv_pkg::item_t                unit_queue[$];
    logic [sgr_cv_pkg::VerdWidth-1:0] verdict_queue[$];
    sgr_cv_pkg::item_t                next_beat;
    logic [sgr_cv_pkg::VerdWidth-1:0] expected_verdict;

    // Idling controls, changed only on the falling edge.
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_req      = 1'b0;

    // Hold-off counter, owned by its own process.
    bit          hold_ack      = 1'b0;
    int unsigned hold_left     = 0;

    int unsigned units_queued = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;

    // Predictor state for the string being parsed.
    logic [sgr_cv_pkg::PhaseWidth-1:0] fld_phase    = sgr_cv_pkg::PH_NORMAL;
    logic [sgr_cv_pkg::AccWidth-1:0]   fld_value    = '0;
    logic                              str_bad      = 1'b0;
    logic [1:0]                        str_len      = '0;
    logic                              str_all_zero = 1'b1;

    sgr_color_code_validator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .code_unit (code_unit),
        .terminal  (terminal),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .verdict   (verdict)
    );

    always #5 clk = ~clk;

    // Codes that are accepted on their own in the normal phase.
    function automatic bit code_is_plain(input logic [sgr_cv_pkg::AccWidth-1:0] n);
        if ((n <= 10'd4) || ((n >= 10'd30) && (n <= 10'd37))
            || ((n >= 10'd40) && (n <= 10'd47))
            || ((n >= 10'd90) && (n <= 10'd97)) || ((n >= 10'd100) && (n <= 10'd107)))
            return 1'b1;
        case (n)
            10'd7, 10'd9, 10'd21, 10'd22, 10'd23, 10'd24, 10'd25, 10'd27, 10'd29,
            10'd39, 10'd49, 10'd53, 10'd55, 10'd59: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Closes one field of the string; advances the extended colour phase.
    function automatic bit close_field(input logic [sgr_cv_pkg::AccWidth-1:0] n);
        if (fld_phase == sgr_cv_pkg::PH_NORMAL)
        begin
            if ((n == sgr_cv_pkg::N_FG_EXT) || (n == sgr_cv_pkg::N_BG_EXT))
            begin
                fld_phase = sgr_cv_pkg::PH_XCOLOR;
                return 1'b1;
            end
            return code_is_plain(n);
        end
        if (fld_phase == sgr_cv_pkg::PH_XCOLOR)
        begin
            if (n == sgr_cv_pkg::N_MODE_RGB)
            begin
                fld_phase = sgr_cv_pkg::PH_BYTE3;
                return 1'b1;
            end
            if (n == sgr_cv_pkg::N_MODE_IDX)
            begin
                fld_phase = sgr_cv_pkg::PH_BYTE1;
                return 1'b1;
            end
            return 1'b0;
        end
        if ((fld_phase >= sgr_cv_pkg::PH_BYTE1) && (fld_phase <= sgr_cv_pkg::PH_BYTE3)
            && (n <= sgr_cv_pkg::BYTE_MAX))
        begin
            fld_phase = fld_phase - 3'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the predictor by one accepted beat; a terminating beat yields a verdict.
    function automatic void track_code_unit(input logic [sgr_cv_pkg::CuWidth-1:0] cu,
                                            input logic term);
        logic [sgr_cv_pkg::VerdWidth-1:0] v;
        int unsigned                      grown;
        if (term || (cu == sgr_cv_pkg::CU_NUL))
        begin
            if (str_len == 2'd0)
                v = sgr_cv_pkg::VERDICT_NONE;
            else if ((str_len <= 2'd2) && str_all_zero)
                v = sgr_cv_pkg::VERDICT_NONE;
            else if (str_bad)
                v = sgr_cv_pkg::VERDICT_INVALID;
            else if (close_field(fld_value))
                v = sgr_cv_pkg::VERDICT_VALID;
            else
                v = sgr_cv_pkg::VERDICT_INVALID;
            verdict_queue.push_back(v);
            fld_phase    = sgr_cv_pkg::PH_NORMAL;
            fld_value    = '0;
            str_bad      = 1'b0;
            str_len      = '0;
            str_all_zero = 1'b1;
            return;
        end
        if (str_len != 2'd3)
            str_len = str_len + 2'd1;
        if (cu != sgr_cv_pkg::CU_ZERO)
            str_all_zero = 1'b0;
        if (str_bad)
            return;
        if (cu == sgr_cv_pkg::CU_SEMI)
        begin
            if (!close_field(fld_value))
                str_bad = 1'b1;
            fld_value = '0;
        end
        else if ((cu >= sgr_cv_pkg::CU_ZERO) && (cu <= sgr_cv_pkg::CU_NINE))
        begin
            grown = 32'(fld_value) * 32'd10 + 32'(cu - sgr_cv_pkg::CU_ZERO);
            fld_value = (grown > 32'(sgr_cv_pkg::ACC_MAX)) ? sgr_cv_pkg::ACC_MAX
                                                           : grown[sgr_cv_pkg::AccWidth-1:0];
        end
        else
        begin
            str_bad = 1'b1;
        end
    endfunction

    function automatic void note_mismatch(input string what,
                                          input logic [sgr_cv_pkg::VerdWidth-1:0] exp_v,
                                          input logic [sgr_cv_pkg::VerdWidth-1:0] got_v);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s: expected verdict %0d, got %0d", $realtime, what, exp_v, got_v);
    endfunction

    task automatic push_unit(input logic [sgr_cv_pkg::CuWidth-1:0] cu, input logic term);
        sgr_cv_pkg::item_t b;
        b.code_unit = cu;
        b.terminal  = term;
        unit_queue.push_back(b);
        units_queued++;
    endtask

    // Pushes a decimal number, sometimes with a leading zero.
    task automatic push_number(input int unsigned value);
        int unsigned digits[$];
        if ($urandom_range(0, 9) == 0)
            push_unit(sgr_cv_pkg::CU_ZERO, 1'b0);
        do
        begin
            digits.push_front(value % 10);
            value = value / 10;
        end
        while (value != 0);
        foreach (digits[i])
            push_unit(sgr_cv_pkg::CU_ZERO + 16'(digits[i]), 1'b0);
    endtask

    function automatic logic [sgr_cv_pkg::CuWidth-1:0] noise_unit();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return sgr_cv_pkg::CU_ZERO + 16'($urandom_range(0, 9));
        if (pick < 6)
            return sgr_cv_pkg::CU_SEMI;
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic int unsigned colour_byte();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            return 0;
        if (pick < 6)
            return 255;
        if (pick < 8)
            return $urandom_range(256, 400);
        return $urandom_range(0, 255);
    endfunction

    // Extended colour: 38 or 48, a mode and its bytes, now and then cut short.
    task automatic push_ext_colour();
        int unsigned pick;
        int unsigned count;
        push_number($urandom_range(0, 1) ? 32'(sgr_cv_pkg::N_FG_EXT)
                                         : 32'(sgr_cv_pkg::N_BG_EXT));
        if ($urandom_range(0, 9) == 0)
            return;
        push_unit(sgr_cv_pkg::CU_SEMI, 1'b0);
        pick = $urandom_range(0, 19);
        if (pick < 9)
        begin
            push_number(32'(sgr_cv_pkg::N_MODE_IDX));
            count = 1;
        end
        else if (pick < 18)
        begin
            push_number(32'(sgr_cv_pkg::N_MODE_RGB));
            count = 3;
        end
        else
        begin
            push_number($urandom_range(0, 9));
            count = $urandom_range(0, 3);
        end
        if ($urandom_range(0, 9) == 0)
            count = $urandom_range(0, count);
        repeat (count)
        begin
            push_unit(sgr_cv_pkg::CU_SEMI, 1'b0);
            push_number(colour_byte());
        end
    endtask

    // One random colour string with its end beat.
    task automatic push_random_string();
        int unsigned kind;
        int unsigned fields;
        int unsigned pick;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            // Default forms and near misses of them.
            repeat ($urandom_range(0, 3))
                push_unit(sgr_cv_pkg::CU_ZERO, 1'b0);
            if ($urandom_range(0, 3) == 0)
            begin
                push_unit(sgr_cv_pkg::CU_SEMI, 1'b0);
                push_unit(sgr_cv_pkg::CU_ZERO, 1'b0);
            end
        end
        else if (kind < 20)
        begin
            repeat ($urandom_range(1, 6))
                push_unit(noise_unit(), 1'b0);
        end
        else
        begin
            fields = $urandom_range(1, 4);
            for (int k = 0; k < fields; k++)
            begin
                if (k != 0)
                    push_unit(sgr_cv_pkg::CU_SEMI, 1'b0);
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    do
                        pick = $urandom_range(0, 107);
                    while (!code_is_plain(10'(pick)));
                    push_number(pick);
                end
                else if (pick < 85)
                    push_ext_colour();
                else if (pick < 92)
                    push_number($urandom_range(0, 1200));
                else if (pick < 96)
                    push_number($urandom_range(1000, 99999));
            end
            // A broken string: a stray character somewhere after the numbers.
            if (kind >= 90)
            begin
                push_unit(noise_unit(), 1'b0);
                if ($urandom_range(0, 1))
                    push_number($urandom_range(0, 107));
            end
        end
        if ($urandom_range(0, 1))
            push_unit(16'($urandom_range(0, 65535)), 1'b1);
        else
            push_unit(sgr_cv_pkg::CU_NUL, 1'b0);
    endtask

    task automatic wait_drained();
        while ((unit_queue.size() != 0) || in_valid || (verdict_queue.size() != 0))
            @(negedge clk);
    endtask

    // Sender: presents the next beat once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            code_unit <= '0;
            terminal  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_code_unit(code_unit, terminal);
            if (!in_valid || in_ready)
            begin
                if ((unit_queue.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct))
                begin
                    next_beat = unit_queue.pop_front();
                    in_valid  <= 1'b1;
                    code_unit <= next_beat.code_unit;
                    terminal  <= next_beat.terminal;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_ack  <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each verdict beat against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    note_mismatch("verdict with none expected", 'x, verdict);
                end
                else
                begin
                    expected_verdict = verdict_queue.pop_front();
                    if (verdict !== expected_verdict)
                        note_mismatch("verdict mismatch", expected_verdict, verdict);
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings: empty, the default forms, an empty field followed
        // by a stray character, an unfinished extended colour, a saturating
        // number and a trailing separator.
        push_unit(sgr_cv_pkg::CU_NUL, 1'b1);
        push_unit(sgr_cv_pkg::CU_ZERO, 1'b0);
        push_unit(sgr_cv_pkg::CU_NUL, 1'b0);
        push_unit(sgr_cv_pkg::CU_ZERO, 1'b0);
        push_unit(sgr_cv_pkg::CU_ZERO, 1'b0);
        push_unit(16'hFFFF, 1'b1);
        push_unit(sgr_cv_pkg::CU_SEMI, 1'b0);
        push_unit(16'hFFFF, 1'b0);
        push_unit(sgr_cv_pkg::CU_NUL, 1'b1);
        push_number(38);
        push_unit(sgr_cv_pkg::CU_SEMI, 1'b0);
        push_number(2);
        push_unit(sgr_cv_pkg::CU_SEMI, 1'b0);
        push_number(1);
        push_unit(sgr_cv_pkg::CU_NUL, 1'b1);
        repeat (5)
            push_unit(sgr_cv_pkg::CU_NINE, 1'b0);
        push_unit(sgr_cv_pkg::CU_NUL, 1'b1);
        push_unit(sgr_cv_pkg::CU_ZERO + 16'd5, 1'b0);
        push_unit(sgr_cv_pkg::CU_SEMI, 1'b0);
        push_unit(sgr_cv_pkg::CU_NUL, 1'b0);
        wait_drained();

        // Random strings under each idling pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 81;
                end
                default:
                begin
                    send_idle_pct = 30;
                    stall_pct     = 30;
                end
            endcase
            units_queued = 0;
            while (units_queued < UNITS_PER_PHASE)
                push_random_string();
            wait_drained();
        end

        // Back-pressure: the receiver holds off while short strings keep coming.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = ~hold_req;
        @(negedge clk);
        repeat (40)
        begin
            if ($urandom_range(0, 1))
                push_unit(sgr_cv_pkg::CU_ZERO + 16'd7, 1'b0);
            push_unit(16'($urandom_range(0, 65535)), 1'b1);
        end
        wait_drained();

        repeat (20) @(negedge clk);
        if ((mismatches == 0) && (verdict_queue.size() == 0))
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
